// ===== hdl/extended_euclid_modular_inverse_unit_macros.svh =====
// assertion macros for the extended euclid modular inverse unit
// no dependencies; included by the top level only
`ifndef EXTENDED_EUCLID_MODULAR_INVERSE_UNIT_MACROS_SVH
`define EXTENDED_EUCLID_MODULAR_INVERSE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EEMI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("eemi assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define EEMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("eemi assertion failed: next-cycle implication");

`endif

// ===== hdl/eemi_pkg.sv =====
// widths and shared types for the extended euclid modular inverse unit
// no dependencies
package eemi_pkg;

    localparam int WIDTH  = 32;
    localparam int UWIDTH = WIDTH - 1;
    localparam int CNT_W  = $clog2(UWIDTH);

    typedef logic [WIDTH-1:0]  t_sword;
    typedef logic [UWIDTH-1:0] t_uword;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [2:0]        t_state;

endpackage

// ===== hdl/extended_euclid_modular_inverse_unit.sv =====
// Extended Euclid modular inverse unit: top level with sequencer and bit-serial divider.
// Depends on eemi_pkg and extended_euclid_modular_inverse_unit_macros.svh.
//
// Takes a signed number and an unsigned modulus, runs the extended Euclidean algorithm on
// (|number|, modulus) and returns the gcd, the Bezout coefficients and the modular inverse
// (0 when the gcd exceeds one). One transaction is in work at a time; o_ready is high only
// while the unit is idle. Each Euclid iteration runs a restoring one-bit-per-cycle divider,
// which also accumulates q*s and q*t by shift-and-add, followed by one update step. A zero
// modulus skips the divider and goes straight to the finish state. The result sits in an
// output register, so a new transaction is accepted while the previous result still waits.
`include "extended_euclid_modular_inverse_unit_macros.svh"

module extended_euclid_modular_inverse_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [eemi_pkg::WIDTH-1:0]     i_number,
    input  logic        [eemi_pkg::UWIDTH-1:0]    i_modulus,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic        [eemi_pkg::UWIDTH-1:0]    o_gcd_value,
    output logic signed [eemi_pkg::WIDTH-1:0]     o_coef_number,
    output logic signed [eemi_pkg::WIDTH-1:0]     o_coef_modulus,
    output logic        [eemi_pkg::UWIDTH-1:0]    o_inverse
);

    localparam eemi_pkg::t_state ST_IDLE   = 3'd0;
    localparam eemi_pkg::t_state ST_DIV    = 3'd1;
    localparam eemi_pkg::t_state ST_UPDATE = 3'd2;
    localparam eemi_pkg::t_state ST_FINISH = 3'd3;

    eemi_pkg::t_state r_state, n_state;
    eemi_pkg::t_cnt   r_cnt, n_cnt;
    eemi_pkg::t_uword r_old_r, n_old_r, r_r, n_r;
    eemi_pkg::t_uword r_rem, n_rem, r_dvd, n_dvd, r_mod, n_mod;
    eemi_pkg::t_sword r_old_s, n_old_s, r_s, n_s;
    eemi_pkg::t_sword r_old_t, n_old_t, r_t, n_t;
    eemi_pkg::t_sword r_acc_s, n_acc_s, r_acc_t, n_acc_t;

    logic             r_out_valid, n_out_valid;
    eemi_pkg::t_uword r_out_gcd, n_out_gcd, r_out_inv, n_out_inv;
    eemi_pkg::t_sword r_out_x, n_out_x, r_out_y, n_out_y;

    logic                          in_fire;
    logic                          num_neg;
    eemi_pkg::t_sword              neg_val;
    eemi_pkg::t_uword              mag;
    logic [eemi_pkg::UWIDTH:0]     rem_sh;
    logic [eemi_pkg::UWIDTH+1:0]   diff;
    logic                          q_bit;
    eemi_pkg::t_sword              x_plus_mod;

    assign in_fire = i_valid && (r_state == ST_IDLE);

    // magnitude of the number; only the most negative code saturates
    always_comb begin
        num_neg = i_number[eemi_pkg::WIDTH-1];
        neg_val = eemi_pkg::t_sword'(0) - eemi_pkg::t_sword'(i_number);
        if (!num_neg) begin
            mag = i_number[eemi_pkg::UWIDTH-1:0];
        end else if (neg_val[eemi_pkg::WIDTH-1]) begin
            mag = '1;
        end else begin
            mag = neg_val[eemi_pkg::UWIDTH-1:0];
        end
    end

    // one restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_dvd[eemi_pkg::UWIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_r};
        q_bit  = !diff[eemi_pkg::UWIDTH+1];
    end

    assign x_plus_mod = r_old_s + {1'b0, r_mod};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_old_r     = r_old_r;
        n_r         = r_r;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_mod       = r_mod;
        n_old_s     = r_old_s;
        n_s         = r_s;
        n_old_t     = r_old_t;
        n_t         = r_t;
        n_acc_s     = r_acc_s;
        n_acc_t     = r_acc_t;
        n_out_valid = r_out_valid;
        n_out_gcd   = r_out_gcd;
        n_out_inv   = r_out_inv;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_old_r = mag;
                    n_r     = i_modulus;
                    n_mod   = i_modulus;
                    n_old_s = eemi_pkg::t_sword'(1);
                    n_s     = '0;
                    n_old_t = '0;
                    n_t     = eemi_pkg::t_sword'(1);
                    n_rem   = '0;
                    n_dvd   = mag;
                    n_acc_s = '0;
                    n_acc_t = '0;
                    n_cnt   = eemi_pkg::t_cnt'(eemi_pkg::UWIDTH - 1);
                    n_state = (i_modulus == '0) ? ST_FINISH : ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem   = q_bit ? diff[eemi_pkg::UWIDTH-1:0] : rem_sh[eemi_pkg::UWIDTH-1:0];
                n_dvd   = {r_dvd[eemi_pkg::UWIDTH-2:0], 1'b0};
                n_acc_s = {r_acc_s[eemi_pkg::WIDTH-2:0], 1'b0} + (q_bit ? r_s : '0);
                n_acc_t = {r_acc_t[eemi_pkg::WIDTH-2:0], 1'b0} + (q_bit ? r_t : '0);
                if (r_cnt == '0) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_cnt = r_cnt - eemi_pkg::t_cnt'(1);
                end
            end
            ST_UPDATE: begin
                n_old_r = r_r;
                n_r     = r_rem;
                n_old_s = r_s;
                n_s     = r_old_s - r_acc_s;
                n_old_t = r_t;
                n_t     = r_old_t - r_acc_t;
                n_dvd   = r_r;
                n_rem   = '0;
                n_acc_s = '0;
                n_acc_t = '0;
                n_cnt   = eemi_pkg::t_cnt'(eemi_pkg::UWIDTH - 1);
                n_state = (r_rem == '0) ? ST_FINISH : ST_DIV;
            end
            ST_FINISH: begin
                // wait until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_gcd   = r_old_r;
                    n_out_x     = r_old_s;
                    n_out_y     = r_old_t;
                    if (r_old_r > eemi_pkg::t_uword'(1)) begin
                        n_out_inv = '0;
                    end else if (r_old_s[eemi_pkg::WIDTH-1]) begin
                        n_out_inv = x_plus_mod[eemi_pkg::UWIDTH-1:0];
                    end else begin
                        n_out_inv = r_old_s[eemi_pkg::UWIDTH-1:0];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_old_r   <= n_old_r;
        r_r       <= n_r;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_mod     <= n_mod;
        r_old_s   <= n_old_s;
        r_s       <= n_s;
        r_old_t   <= n_old_t;
        r_t       <= n_t;
        r_acc_s   <= n_acc_s;
        r_acc_t   <= n_acc_t;
        r_out_gcd <= n_out_gcd;
        r_out_inv <= n_out_inv;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_gcd_value    = r_out_gcd;
    assign o_coef_number  = r_out_x;
    assign o_coef_modulus = r_out_y;
    assign o_inverse      = r_out_inv;

    `EEMI_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, r_state == ST_DIV, (r_r != '0) && (r_rem < r_r))
    `EEMI_ASSERT_NEXT(a_zero_mod_skips_loop, i_clk, i_rst_n, in_fire && (i_modulus == '0), r_state == ST_FINISH)
    `EEMI_ASSERT_IMPL(a_no_inverse_when_gcd_big, i_clk, i_rst_n, r_out_valid && (r_out_gcd > eemi_pkg::t_uword'(1)), r_out_inv == '0)

endmodule

// ===== tb/sv/tb_extended_euclid_modular_inverse_unit.sv =====
// self-checking testbench for extended_euclid_modular_inverse_unit: directed table, then random
// operands under three idling phases, checked against typed rows or a behavioral euclid predictor
// depends on eemi_pkg and the unit's rtl
`timescale 1ns / 100ps

module tb_extended_euclid_modular_inverse_unit;

    localparam int STALL_LIMIT    = 20000;
    localparam int ITEMS_PER_PASS = 135;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        eemi_pkg::t_uword gcd_value;
        eemi_pkg::t_sword coef_number;
        eemi_pkg::t_sword coef_modulus;
        eemi_pkg::t_uword inverse;
    } euclid_result_t;

    typedef struct packed {
        eemi_pkg::t_sword number;
        eemi_pkg::t_uword modulus;
        logic             typed;
        euclid_result_t   want;
    } directed_case_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    eemi_pkg::t_sword    i_number = '0;
    eemi_pkg::t_uword    i_modulus = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    eemi_pkg::t_uword    o_gcd_value;
    eemi_pkg::t_sword    o_coef_number;
    eemi_pkg::t_sword    o_coef_modulus;
    eemi_pkg::t_uword    o_inverse;

    euclid_result_t expected_results[$];
    directed_case_t directed_cases[$];
    int unsigned    mismatch_count = 0;
    int unsigned    stall_cycles = 0;
    int unsigned    sender_idle_pct = 19;
    int unsigned    receiver_idle_pct = 70;

    extended_euclid_modular_inverse_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_modulus      (i_modulus),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gcd_value    (o_gcd_value),
        .o_coef_number  (o_coef_number),
        .o_coef_modulus (o_coef_modulus),
        .o_inverse      (o_inverse)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // extended euclid on (|number|, modulus) in 64-bit wraparound arithmetic
    function automatic euclid_result_t predict_euclid(input eemi_pkg::t_sword num,
                                                      input eemi_pkg::t_uword modv);
        bit [63:0]      wmask;
        bit [63:0]      umask;
        bit [63:0]      mag;
        bit [63:0]      rem_prev, rem_cur, s_prev, s_cur, t_prev, t_cur;
        bit [63:0]      quo, nxt, inv;
        euclid_result_t res;
        wmask = (eemi_pkg::WIDTH >= 64) ? ~64'd0 : ((64'd1 << eemi_pkg::WIDTH) - 64'd1);
        umask = (eemi_pkg::UWIDTH >= 64) ? ~64'd0 : ((64'd1 << eemi_pkg::UWIDTH) - 64'd1);
        if (num[eemi_pkg::WIDTH-1]) begin
            mag = (64'd0 - 64'(num)) & wmask;
            // most negative input saturates to the largest magnitude
            if (mag > umask) begin
                mag = umask;
            end
        end else begin
            mag = 64'(num);
        end
        rem_prev = mag;
        rem_cur  = 64'(modv);
        s_prev   = 64'd1;
        s_cur    = 64'd0;
        t_prev   = 64'd0;
        t_cur    = 64'd1;
        while (rem_cur != 64'd0) begin
            quo      = rem_prev / rem_cur;
            nxt      = rem_prev - quo * rem_cur;
            rem_prev = rem_cur;
            rem_cur  = nxt;
            nxt      = s_prev - quo * s_cur;
            s_prev   = s_cur;
            s_cur    = nxt;
            nxt      = t_prev - quo * t_cur;
            t_prev   = t_cur;
            t_cur    = nxt;
        end
        if (rem_prev > 64'd1) begin
            inv = 64'd0;
        end else if (s_prev[63]) begin
            inv = s_prev + 64'(modv);
        end else begin
            inv = s_prev;
        end
        res.gcd_value    = rem_prev[eemi_pkg::UWIDTH-1:0];
        res.coef_number  = s_prev[eemi_pkg::WIDTH-1:0];
        res.coef_modulus = t_prev[eemi_pkg::WIDTH-1:0];
        res.inverse      = inv[eemi_pkg::UWIDTH-1:0];
        return res;
    endfunction

    task automatic pick_random_operands(output eemi_pkg::t_sword num,
                                        output eemi_pkg::t_uword modv);
        int unsigned fa, fb, fc, factor, n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                num  = $urandom;
                modv = eemi_pkg::t_uword'($urandom);
            end
            4: begin
                num  = eemi_pkg::t_sword'(int'($urandom_range(0, 200)) - 100);
                modv = eemi_pkg::t_uword'($urandom_range(0, 100));
            end
            5: begin
                num  = $urandom;
                modv = eemi_pkg::t_uword'($urandom_range(0, 2));
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: num = 32'h8000_0000;
                    1: num = 32'h7FFF_FFFF;
                    2: num = 32'h8000_0001;
                    3: num = '0;
                    4: num = 32'd1;
                    default: num = '1;
                endcase
                modv = eemi_pkg::t_uword'($urandom);
            end
            7: begin
                // common factor, so gcd exceeds one
                factor = $urandom_range(2, 1000);
                num    = eemi_pkg::t_sword'(factor * $urandom_range(1, 2000000));
                if ($urandom_range(0, 1) == 1) begin
                    num = -num;
                end
                modv = eemi_pkg::t_uword'(factor * $urandom_range(0, 2000000));
            end
            8: begin
                // consecutive fibonacci numbers give the longest iteration chains
                n  = $urandom_range(1, 45);
                fa = 0;
                fb = 1;
                repeat (n) begin
                    fc = fa + fb;
                    fa = fb;
                    fb = fc;
                end
                if ($urandom_range(0, 1) == 1) begin
                    num  = eemi_pkg::t_sword'(fb);
                    modv = eemi_pkg::t_uword'(fa);
                end else begin
                    num  = eemi_pkg::t_sword'(fa);
                    modv = eemi_pkg::t_uword'(fb);
                end
                if ($urandom_range(0, 1) == 1) begin
                    num = -num;
                end
            end
            default: begin
                num  = $urandom;
                modv = eemi_pkg::t_uword'($urandom >> $urandom_range(0, 30));
            end
        endcase
    endtask

    // holds valid until o_ready is seen at a rising edge
    task automatic send_operands(input eemi_pkg::t_sword num, input eemi_pkg::t_uword modv,
                                 input euclid_result_t want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_number  <= num;
        i_modulus <= modv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(want);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        euclid_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected: gcd_value=%0d inverse=%0d",
                       o_gcd_value, o_inverse);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_gcd_value !== want.gcd_value) begin
                    $error("gcd_value: expected %0d, got %0d", want.gcd_value, o_gcd_value);
                    mismatch_count++;
                end
                if (o_coef_number !== want.coef_number) begin
                    $error("coef_number: expected %0d, got %0d",
                           $signed(want.coef_number), $signed(o_coef_number));
                    mismatch_count++;
                end
                if (o_coef_modulus !== want.coef_modulus) begin
                    $error("coef_modulus: expected %0d, got %0d",
                           $signed(want.coef_modulus), $signed(o_coef_modulus));
                    mismatch_count++;
                end
                if (o_inverse !== want.inverse) begin
                    $error("inverse: expected %0d, got %0d", want.inverse, o_inverse);
                    mismatch_count++;
                end
            end
        end
    end

    // counts cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        directed_case_t   row;
        eemi_pkg::t_sword num;
        eemi_pkg::t_uword modv;
        int               pass_idx;

        // zero modulus: loop never runs, expectations typed in
        directed_cases.push_back('{32'sd0, 31'd0, 1'b1, '{31'd0, 32'sd1, 32'sd0, 31'd1}});
        directed_cases.push_back('{32'sd1, 31'd0, 1'b1, '{31'd1, 32'sd1, 32'sd0, 31'd1}});
        directed_cases.push_back('{-32'sd1, 31'd0, 1'b1, '{31'd1, 32'sd1, 32'sd0, 31'd1}});
        directed_cases.push_back('{32'sd5, 31'd0, 1'b1, '{31'd5, 32'sd1, 32'sd0, 31'd0}});
        directed_cases.push_back('{32'h7FFF_FFFF, 31'd0, 1'b1,
                                   '{31'h7FFF_FFFF, 32'sd1, 32'sd0, 31'd0}});
        directed_cases.push_back('{32'h8000_0001, 31'd0, 1'b1,
                                   '{31'h7FFF_FFFF, 32'sd1, 32'sd0, 31'd0}});
        // most negative number saturates
        directed_cases.push_back('{32'h8000_0000, 31'd0, 1'b1,
                                   '{31'h7FFF_FFFF, 32'sd1, 32'sd0, 31'd0}});
        // modulus one and the rest go through the predictor
        directed_cases.push_back('{32'sd7, 31'd1, 1'b0, '0});
        directed_cases.push_back('{-32'sd7, 31'd1, 1'b0, '0});
        directed_cases.push_back('{32'sd0, 31'd1, 1'b0, '0});
        directed_cases.push_back('{32'sd0, 31'd5, 1'b0, '0});
        directed_cases.push_back('{32'sd3, 31'd7, 1'b0, '0});
        directed_cases.push_back('{-32'sd3, 31'd7, 1'b0, '0});
        directed_cases.push_back('{32'sd6, 31'd9, 1'b0, '0});
        directed_cases.push_back('{32'sd12, 31'd18, 1'b0, '0});
        directed_cases.push_back('{32'sd1, 31'h7FFF_FFFF, 1'b0, '0});
        directed_cases.push_back('{32'sd17, 31'h7FFF_FFFF, 1'b0, '0});
        directed_cases.push_back('{32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, '0});
        directed_cases.push_back('{32'h8000_0001, 31'h7FFF_FFFE, 1'b0, '0});
        directed_cases.push_back('{32'h8000_0000, 31'h7FFF_FFFF, 1'b0, '0});
        directed_cases.push_back('{32'h8000_0000, 31'h7FFF_FFFE, 1'b0, '0});
        directed_cases.push_back('{32'sd1836311903, 31'd1134903170, 1'b0, '0});
        directed_cases.push_back('{-32'sd1836311903, 31'd1134903170, 1'b0, '0});
        directed_cases.push_back('{32'sd1134903170, 31'd1836311903, 1'b0, '0});
        directed_cases.push_back('{32'h5555_5555, 31'h2AAA_AAAB, 1'b0, '0});
        directed_cases.push_back('{32'hAAAA_AAAB, 31'h5555_5555, 1'b0, '0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cases[idx]) begin
            row = directed_cases[idx];
            send_operands(row.number, row.modulus,
                          row.typed ? row.want : predict_euclid(row.number, row.modulus));
        end

        for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
            // sender holds off until the unit has drained
            @(negedge i_clk);
            i_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge i_clk);
            case (pass_idx)
                0: begin
                    sender_idle_pct   = 19;
                    receiver_idle_pct = 70;
                end
                1: begin
                    sender_idle_pct   = 70;
                    receiver_idle_pct = 19;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PASS) begin
                pick_random_operands(num, modv);
                send_operands(num, modv, predict_euclid(num, modv));
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
